[hw/rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;
   localparam logic [2:0] OP_NORM = 3'd5;

   localparam logic [1:0] ORD_LESS = 2'd0;
   localparam logic [1:0] ORD_EQUAL = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_TWOS,
      RS_STEP,
      RS_DIV_N,
      RS_DIV_D
   } red_state_type;

   typedef enum logic [2:0] {
      TS_IDLE,
      TS_START,
      TS_RED_WAIT,
      TS_MUL_A,
      TS_MUL_B,
      TS_MUL_C,
      TS_FINISH
   } top_state_type;

   typedef enum logic [1:0] {
      PH_A,
      PH_B,
      PH_R
   } phase_type;

endpackage

[hw/rtl/rau_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_channels
// Valid/ready channels for operand and result transactions.
// ----------------------------------------------------------------------------
interface rau_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        operation;
   logic signed [31:0] a_num;
   logic signed [31:0] a_den;
   logic signed [31:0] b_num;
   logic signed [31:0] b_den;

   modport source(output valid, operation, a_num, a_den, b_num, b_den, input ready);
   modport sink(input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] result_num;
   logic [30:0]       result_den;
   logic [1:0]        order;

   modport source(output valid, result_num, result_den, order, input ready);
   modport sink(input valid, result_num, result_den, order, output ready);
endinterface

[hw/rtl/rau_reducer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_reducer
// Reduces a fraction by the binary gcd of its magnitudes, then divides both
// magnitudes by the gcd with a restoring divider on one shared subtractor.
// ----------------------------------------------------------------------------
module rau_reducer #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] n_value,
   input  logic signed [WORD_BITS-1:0] d_value,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] num,
   output logic [WORD_BITS-1:0]        den
);
   localparam int W = WORD_BITS;
   localparam int KW = $clog2(W);

   rau_pkg::red_state_type state_ff, state_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, nm_ff, nm_in, dm_ff, dm_in, rem_ff, rem_in;
   logic [KW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic neg_ff, neg_in, done_ff, done_in;
   logic signed [W-1:0] num_ff, num_in;
   logic [W-1:0] den_ff, den_in;

   logic [W-1:0] n_mag, d_mag, dvd, dq;
   logic [W:0] sub_a, sub_b, diff, sh;
   logic q_bit;

   assign n_mag = n_value[W-1] ? (~n_value) + W'(1) : n_value;
   assign d_mag = d_value[W-1] ? (~d_value) + W'(1) : d_value;
   assign dvd = (state_ff == rau_pkg::RS_DIV_N) ? nm_ff : dm_ff;
   assign sh = {rem_ff, dvd[W-1]};
   assign diff = sub_a - sub_b;
   assign q_bit = !diff[W];
   assign dq = {dvd[W-2:0], q_bit};

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      nm_in = nm_ff;
      dm_in = dm_ff;
      rem_in = rem_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      num_in = num_ff;
      den_in = den_ff;
      done_in = 1'b0;
      sub_a = {1'b0, x_ff};
      sub_b = {1'b0, y_ff};
      if (state_ff == rau_pkg::RS_DIV_N || state_ff == rau_pkg::RS_DIV_D) begin
         sub_a = sh;
         sub_b = {1'b0, x_ff};
      end
      unique case (state_ff)
         rau_pkg::RS_IDLE: begin
            if (start) begin
               neg_in = n_value[W-1] ^ d_value[W-1];
               x_in = n_mag;
               y_in = d_mag;
               nm_in = n_mag;
               dm_in = d_mag;
               k_in = '0;
               if (d_mag == '0) begin
                  num_in = (n_mag != '0) ? W'(1) : '0;
                  den_in = W'(1);
                  done_in = 1'b1;
               end else if (n_mag == '0) begin
                  num_in = '0;
                  den_in = W'(1);
                  done_in = 1'b1;
               end else begin
                  state_in = rau_pkg::RS_TWOS;
               end
            end
         end
         rau_pkg::RS_TWOS: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + KW'(1);
            end else begin
               state_in = rau_pkg::RS_STEP;
            end
         end
         rau_pkg::RS_STEP: begin
            if (y_ff == '0) begin
               x_in = x_ff << k_ff;
               rem_in = '0;
               cnt_in = '0;
               state_in = rau_pkg::RS_DIV_N;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!diff[W] && diff != '0) begin
               x_in = diff[W-1:0];
            end else begin
               y_in = W'(0) - diff[W-1:0];
            end
         end
         rau_pkg::RS_DIV_N: begin
            rem_in = q_bit ? diff[W-1:0] : sh[W-1:0];
            nm_in = dq;
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(W - 1)) begin
               rem_in = '0;
               cnt_in = '0;
               state_in = rau_pkg::RS_DIV_D;
            end
         end
         rau_pkg::RS_DIV_D: begin
            rem_in = q_bit ? diff[W-1:0] : sh[W-1:0];
            dm_in = dq;
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(W - 1)) begin
               num_in = neg_ff ? W'(0) - nm_ff : nm_ff;
               den_in = dq;
               done_in = 1'b1;
               state_in = rau_pkg::RS_IDLE;
            end
         end
         default: state_in = rau_pkg::RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::RS_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      nm_ff <= nm_in;
      dm_ff <= dm_in;
      rem_ff <= rem_in;
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign num = num_ff;
   assign den = den_ff;
endmodule

[hw/rtl/rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Add, subtract, multiply, divide, compare or normalize two fractions, with
// every fraction reduced to lowest terms and a positive denominator.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        operation, a_num, a_den, b_num, b_den
//   rsp_ch   out  valid/ready        result_num, result_den, order
//
// each reduction runs a binary gcd and then a divider over both magnitudes,
// all on the one shared subtractor in the reducer
// a transaction runs one (normalize) to three reductions; arithmetic and
// compare also run states TS_MUL_A, TS_MUL_B and TS_MUL_C on one shared multiplier
// req_ch.ready is high only between transactions; one finished result may
// wait in the output register while the next transaction is taken
// reset is synchronous and needs no clearing pass
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
   parameter int WORD_BITS = 32
) (
   input logic    clock,
   input logic    reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);
   localparam int W = WORD_BITS;
   localparam int PW = 2 * W + 2;

   rau_pkg::top_state_type state_ff, state_in;
   rau_pkg::phase_type phase_ff, phase_in;
   logic [2:0] op_ff, op_in;
   logic signed [W-1:0] ran_ff, ran_in, rad_ff, rad_in, rbn_ff, rbn_in, rbd_ff, rbd_in;
   logic signed [W-1:0] an_ff, an_in, bn_ff, bn_in, rn_ff, rn_in;
   logic [W-1:0] ad_ff, ad_in, bd_ff, bd_in;
   logic signed [PW-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [W-1:0] res_num_ff, res_num_in;
   logic [W-1:0] res_den_ff, res_den_in;
   logic [1:0] ord_ff, ord_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_num_ff, rsp_num_in;
   logic [30:0] rsp_den_ff, rsp_den_in;
   logic [1:0] rsp_ord_ff, rsp_ord_in;

   logic signed [W:0] mul_a, mul_b;
   logic signed [PW-1:0] product;
   logic red_start, red_done;
   logic signed [W-1:0] red_n, red_d, red_num;
   logic [W-1:0] red_den;
   logic [W-2:0] den_sat;
   logic is_arith, accept;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == rau_pkg::TS_IDLE);
   assign is_arith = (op_ff == rau_pkg::OP_ADD) || (op_ff == rau_pkg::OP_SUB)
                  || (op_ff == rau_pkg::OP_MUL) || (op_ff == rau_pkg::OP_DIV)
                  || (op_ff == rau_pkg::OP_CMP);
   assign product = mul_a * mul_b;
   assign den_sat = res_den_ff[W-1] ? '1 : res_den_ff[W-2:0];

   rau_reducer #(.WORD_BITS(W)) u_reducer (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .n_value (red_n),
      .d_value (red_d),
      .done    (red_done),
      .num     (red_num),
      .den     (red_den)
   );

   always_comb begin
      unique case (phase_ff)
         rau_pkg::PH_A: begin
            red_n = ran_ff;
            red_d = rad_ff;
         end
         rau_pkg::PH_B: begin
            red_n = rbn_ff;
            red_d = rbd_ff;
         end
         default: begin
            red_n = rn_ff;
            red_d = prod_ff[W-1:0];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      op_in = op_ff;
      ran_in = ran_ff;
      rad_in = rad_ff;
      rbn_in = rbn_ff;
      rbd_in = rbd_ff;
      an_in = an_ff;
      ad_in = ad_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      rn_in = rn_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      ord_in = ord_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_num_in = rsp_num_ff;
      rsp_den_in = rsp_den_ff;
      rsp_ord_in = rsp_ord_ff;
      red_start = 1'b0;
      mul_a = {an_ff[W-1], an_ff};
      mul_b = {1'b0, bd_ff};
      unique case (state_ff)
         rau_pkg::TS_IDLE: begin
            if (accept) begin
               op_in = req_ch.operation;
               ran_in = req_ch.a_num[W-1:0];
               rad_in = req_ch.a_den[W-1:0];
               rbn_in = req_ch.b_num[W-1:0];
               rbd_in = req_ch.b_den[W-1:0];
               phase_in = rau_pkg::PH_A;
               state_in = rau_pkg::TS_START;
            end
         end
         rau_pkg::TS_START: begin
            red_start = 1'b1;
            state_in = rau_pkg::TS_RED_WAIT;
         end
         rau_pkg::TS_RED_WAIT: begin
            if (red_done) begin
               unique case (phase_ff)
                  rau_pkg::PH_A: begin
                     an_in = red_num;
                     ad_in = red_den;
                     res_num_in = red_num;
                     res_den_in = red_den;
                     ord_in = rau_pkg::ORD_LESS;
                     if (is_arith) begin
                        phase_in = rau_pkg::PH_B;
                        state_in = rau_pkg::TS_START;
                     end else begin
                        state_in = rau_pkg::TS_FINISH;
                     end
                  end
                  rau_pkg::PH_B: begin
                     bn_in = red_num;
                     bd_in = red_den;
                     state_in = rau_pkg::TS_MUL_A;
                  end
                  default: begin
                     res_num_in = red_num;
                     res_den_in = red_den;
                     ord_in = rau_pkg::ORD_LESS;
                     state_in = rau_pkg::TS_FINISH;
                  end
               endcase
            end
         end
         rau_pkg::TS_MUL_A: begin
            if (op_ff == rau_pkg::OP_MUL) begin
               mul_b = {bn_ff[W-1], bn_ff};
            end
            prod_in = product;
            state_in = rau_pkg::TS_MUL_B;
         end
         rau_pkg::TS_MUL_B: begin
            mul_a = {bn_ff[W-1], bn_ff};
            mul_b = {1'b0, ad_ff};
            acc_in = prod_ff;
            prod_in = product;
            state_in = rau_pkg::TS_MUL_C;
         end
         rau_pkg::TS_MUL_C: begin
            mul_a = {1'b0, ad_ff};
            mul_b = (op_ff == rau_pkg::OP_DIV) ? {bn_ff[W-1], bn_ff} : {1'b0, bd_ff};
            prod_in = product;
            if (op_ff == rau_pkg::OP_CMP) begin
               res_num_in = '0;
               res_den_in = '0;
               if (acc_ff < prod_ff) begin
                  ord_in = rau_pkg::ORD_LESS;
               end else if (acc_ff == prod_ff) begin
                  ord_in = rau_pkg::ORD_EQUAL;
               end else begin
                  ord_in = rau_pkg::ORD_GREATER;
               end
               state_in = rau_pkg::TS_FINISH;
            end else begin
               if (op_ff == rau_pkg::OP_ADD) begin
                  rn_in = acc_ff[W-1:0] + prod_ff[W-1:0];
               end else if (op_ff == rau_pkg::OP_SUB) begin
                  rn_in = acc_ff[W-1:0] - prod_ff[W-1:0];
               end else begin
                  rn_in = acc_ff[W-1:0];
               end
               phase_in = rau_pkg::PH_R;
               state_in = rau_pkg::TS_START;
            end
         end
         rau_pkg::TS_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in = 32'(res_num_ff);
               rsp_den_in = 31'(den_sat);
               rsp_ord_in = ord_ff;
               state_in = rau_pkg::TS_IDLE;
            end
         end
         default: state_in = rau_pkg::TS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::TS_IDLE;
         phase_ff <= rau_pkg::PH_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ran_ff <= ran_in;
      rad_ff <= rad_in;
      rbn_ff <= rbn_in;
      rbd_ff <= rbd_in;
      an_ff <= an_in;
      ad_ff <= ad_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      rn_ff <= rn_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      ord_ff <= ord_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_ord_ff <= rsp_ord_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.result_num = rsp_num_ff;
   assign rsp_ch.result_den = rsp_den_ff;
   assign rsp_ch.order = rsp_ord_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("transaction accepted while a previous one is running");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      red_done |-> state_ff == rau_pkg::TS_RED_WAIT)
      else $error("reducer finished outside its wait state");

   a_order_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ord_ff != rau_pkg::ORD_LESS |-> rsp_den_ff == '0)
      else $error("compare result carries a denominator");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_den_ff == '0 |-> rsp_num_ff == '0)
      else $error("zero denominator with nonzero numerator");
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rational arithmetic unit: directed corner cases,
// then random fraction pairs, each result compared with a listed value or a
// local predictor of reduction, wrapped cross products and exact compare.
// ----------------------------------------------------------------------------
module tb;

   localparam int W = 32;
   localparam int N_RANDOM = 1230;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic [1:0]         order;
   } result_type;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] an;
      logic signed [31:0] ad;
      logic signed [31:0] bn;
      logic signed [31:0] bd;
      bit                 typed;
      result_type         want;
   } vector_type;

   logic clock = 0;
   logic reset = 1;
   always #1 clock = ~clock;

   rau_req_if req_ch();
   rau_rsp_if rsp_ch();

   rational_arithmetic_unit_core #(.WORD_BITS(W)) i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   result_type pending_results[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      sending_done = 0;
   bit      calm = 0;
   bit      hold_off = 0;

   // magnitudes kept at 33 bits so -2^31 stays exact
   function automatic logic [32:0] gcd33(logic [32:0] x, logic [32:0] y);
      logic [32:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic void lowest_terms(input logic signed [31:0] n,
                                        input logic signed [31:0] d,
                                        output logic signed [31:0] rn,
                                        output logic [32:0] rd);
      logic [32:0] nm, dm, g;
      nm = n < 0 ? 33'(-34'(n)) : 33'(n);
      dm = d < 0 ? 33'(-34'(d)) : 33'(d);
      if (dm == 0) begin
         rn = (nm == 0) ? 0 : 1;
         rd = 1;
      end else if (nm == 0) begin
         rn = 0;
         rd = 1;
      end else begin
         g = gcd33(nm, dm);
         nm = nm / g;
         dm = dm / g;
         rn = ((n < 0) != (d < 0)) ? 32'(-nm) : 32'(nm);
         rd = dm;
      end
   endfunction

   function automatic result_type fraction_result(vector_type v);
      logic signed [31:0] an, bn, rn;
      logic [32:0] ad, bd, rd;
      logic [31:0] n, d;
      logic signed [63:0] lhs, rhs;
      result_type r;
      lowest_terms(v.an, v.ad, an, ad);
      lowest_terms(v.bn, v.bd, bn, bd);
      r = '0;
      if (v.op == rau_pkg::OP_CMP) begin
         lhs = 64'(an) * $signed({31'd0, bd});
         rhs = 64'(bn) * $signed({31'd0, ad});
         r.order = lhs < rhs ? rau_pkg::ORD_LESS
                 : (lhs == rhs ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER);
         return r;
      end
      rn = an;
      rd = ad;
      d = 32'(ad) * 32'(bd);
      case (v.op)
         rau_pkg::OP_ADD: n = 32'(an) * 32'(bd) + 32'(bn) * 32'(ad);
         rau_pkg::OP_SUB: n = 32'(an) * 32'(bd) - 32'(bn) * 32'(ad);
         rau_pkg::OP_MUL: n = 32'(an) * 32'(bn);
         rau_pkg::OP_DIV: begin
            n = 32'(an) * 32'(bd);
            d = 32'(ad) * 32'(bn);
         end
         default: ;
      endcase
      if (v.op <= rau_pkg::OP_DIV) lowest_terms(n, d, rn, rd);
      r.num = rn;
      r.den = rd >= 33'h80000000 ? 31'h7fffffff : rd[30:0];
      return r;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
         1: return $urandom_range(0, 3) - 1;
         2: return $signed(8'($urandom));
         3: return $signed(16'($urandom));
         4: return ($urandom_range(0, 60) * ($urandom_range(0, 1) ? 1 : -1));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_fraction_pair(vector_type v);
      req_ch.valid     <= 1;
      req_ch.operation <= v.op;
      req_ch.a_num     <= v.an;
      req_ch.a_den     <= v.ad;
      req_ch.b_num     <= v.bn;
      req_ch.b_den     <= v.bd;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(v.typed ? v.want : fraction_result(v));
      if (!calm && $urandom_range(0, 99) < 37) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   vector_type directed[$];
   vector_type v;

   function automatic vector_type row(logic [2:0] op, logic signed [31:0] an,
                                   logic signed [31:0] ad, logic signed [31:0] bn,
                                   logic signed [31:0] bd, bit typed = 0,
                                   result_type want = '0);
      vector_type x;
      x.op = op; x.an = an; x.ad = ad; x.bn = bn; x.bd = bd;
      x.typed = typed; x.want = want;
      return x;
   endfunction

   initial begin
      req_ch.valid = 0;
      req_ch.operation = rau_pkg::OP_ADD;
      req_ch.a_num = 0; req_ch.a_den = 0; req_ch.b_num = 0; req_ch.b_den = 0;
      directed.push_back(row(rau_pkg::OP_NORM, 5, 0, 0, 0, 1, '{1, 1, 0}));
      directed.push_back(row(rau_pkg::OP_NORM, 0, 0, 0, 0, 1, '{0, 1, 0}));
      directed.push_back(row(rau_pkg::OP_NORM, 0, -7, 0, 0, 1, '{0, 1, 0}));
      directed.push_back(row(rau_pkg::OP_NORM, 6, -4, 0, 0, 1, '{-3, 2, 0}));
      directed.push_back(row(rau_pkg::OP_NORM, 32'h80000000, -1, 0, 1, 1,
                             '{32'h80000000, 1, 0}));
      directed.push_back(row(rau_pkg::OP_NORM, 1, 32'h80000000, 0, 1, 1,
                             '{-1, 31'h7fffffff, 0}));
      directed.push_back(row(rau_pkg::OP_NORM, 32'h7fffffff, 32'h7fffffff, 0, 1, 1,
                             '{1, 1, 0}));
      directed.push_back(row(3'd6, 4, 8, 1, 1, 1, '{1, 2, 0}));
      directed.push_back(row(3'd7, -9, 3, 1, 1, 1, '{-3, 1, 0}));
      directed.push_back(row(rau_pkg::OP_CMP, 1, 2, 2, 4, 1,
                             '{0, 0, rau_pkg::ORD_EQUAL}));
      directed.push_back(row(rau_pkg::OP_CMP, -1, 2, 1, 3, 1,
                             '{0, 0, rau_pkg::ORD_LESS}));
      directed.push_back(row(rau_pkg::OP_CMP, 1, 0, 0, 5, 1,
                             '{0, 0, rau_pkg::ORD_GREATER}));
      directed.push_back(row(rau_pkg::OP_ADD, 1, 2, 1, 3));
      directed.push_back(row(rau_pkg::OP_SUB, 1, 3, 1, 2));
      directed.push_back(row(rau_pkg::OP_MUL, -2, 3, 3, -4));
      directed.push_back(row(rau_pkg::OP_DIV, 1, 2, 0, 5));
      directed.push_back(row(rau_pkg::OP_DIV, 3, 7, -2, 9));
      directed.push_back(row(rau_pkg::OP_ADD, 32'h7fffffff, 1, 32'h7fffffff, 1));
      directed.push_back(row(rau_pkg::OP_MUL, 32'h80000000, 1, 32'h80000000, 1));
      directed.push_back(row(rau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000));
      directed.push_back(row(rau_pkg::OP_CMP, 32'h80000000, 1, 32'h7fffffff, 1));
      directed.push_back(row(rau_pkg::OP_DIV, 32'hffffffff, 32'h80000000, 32'h80000000,
                             32'hffffffff));
      repeat (3) @(posedge clock);
      reset <= 0;
      foreach (directed[i]) send_fraction_pair(directed[i]);
      // pause until drained
      req_ch.valid <= 0;
      wait (pending_results.size() == 0);
      @(posedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 300 && i < 450);
         v = row(3'($urandom_range(0, 7)), random_word(), random_word(),
                 random_word(), random_word());
         send_fraction_pair(v);
      end
      req_ch.valid <= 0;
      sending_done = 1;
   end

   // receiver: random stalls, plus one long hold-off
   initial begin
      rsp_ch.ready = 0;
      @(negedge reset);
      repeat (40) @(posedge clock);
      rsp_ch.ready <= 0;
      hold_off = 1;
      repeat (3000) @(posedge clock);
      hold_off = 0;
      forever begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         idle_cycles <= 0;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction");
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.result_num !== want.num || rsp_ch.result_den !== want.den ||
                rsp_ch.order !== want.order) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %0d/%0d ord %0d, got %0d/%0d ord %0d",
                           want.num, want.den, want.order, rsp_ch.result_num,
                           rsp_ch.result_den, rsp_ch.order);
            end
         end
      end else if (req_ch.valid && req_ch.ready) begin
         idle_cycles <= 0;
      end else if (!hold_off) begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (sending_done && pending_results.size() == 0);
      repeat (1200) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG);
      $display("tb: done, errors");
      $finish;
   end
endmodule
